// File: design/assert_macros.svh
// Assertion macros shared by the checker modules.
// Each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: design/sdspi_pkg.sv
// Shared types, reset values, status codes and helper functions of the SD SPI host.
// No dependencies.
package sdspi_pkg;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        chip_select;
    logic        fast_clock;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        data_request;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] capacity_blocks;
    logic        high_capacity;
  } res_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] blocks;
  } csd_t;

  localparam int BLOCK_BYTES = 512;
  localparam logic [9:0] BLOCK_BC = 10'(BLOCK_BYTES);

  localparam logic [15:0] INIT_TIMEOUT_RST  = 16'd1000;
  localparam logic [15:0] TOKEN_TIMEOUT_RST = 16'd200;
  localparam logic [15:0] BUSY_TIMEOUT_RST  = 16'd500;
  localparam logic [7:0]  POLL_LIMIT_RST    = 8'd16;
  localparam logic [3:0]  CMD0_ATTEMPTS_RST = 4'd8;
  localparam logic [7:0]  WAKEUP_BYTES_RST  = 8'd16;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CMD0    = 3'd1;
  localparam logic [2:0] ST_CMD8    = 3'd2;
  localparam logic [2:0] ST_ACMD41  = 3'd3;
  localparam logic [2:0] ST_CMD58   = 3'd4;
  localparam logic [2:0] ST_READ    = 3'd5;
  localparam logic [2:0] ST_WRITE   = 3'd6;
  localparam logic [2:0] ST_TIMEOUT = 3'd7;

  function automatic logic [47:0] make_frame(input logic [7:0] cmd, input logic [31:0] arg,
                                             input logic [7:0] crc);
    return {cmd | 8'h40, arg, crc};
  endfunction

  function automatic logic [7:0] frame_byte(input logic [47:0] f, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd1: b = f[47:40];
      3'd2: b = f[39:32];
      3'd3: b = f[31:24];
      3'd4: b = f[23:16];
      3'd5: b = f[15:8];
      3'd6: b = f[7:0];
      default: b = 8'hFF;
    endcase
    return b;
  endfunction

  function automatic csd_t decode_csd(input logic [7:0] b0, input logic [7:0] b5,
                                      input logic [7:0] b6, input logic [7:0] b7,
                                      input logic [7:0] b8, input logic [7:0] b9,
                                      input logic [7:0] b10);
    csd_t        res;
    logic [11:0] cs1;
    logic [2:0]  mult;
    logic [4:0]  e;
    logic [31:0] base;
    logic [21:0] cs2;
    logic [32:0] big;
    res = '0;
    cs1 = {b6[1:0], b7, b8[7:6]};
    mult = {b9[1:0], b10[7]};
    e = 5'(mult) + 5'(b5[3:0]);
    base = 32'(cs1) + 32'd1;
    cs2 = {b7[5:0], b8, b9};
    big = (33'(cs2) + 33'd1) << 10;
    case (b0[7:6])
      2'd0: begin
        res.ok = 1'b1;
        if (e >= 5'd7) res.blocks = base << (e - 5'd7);
        else res.blocks = base >> (5'd7 - e);
      end
      2'd1: begin
        res.ok = 1'b1;
        res.blocks = big[32] ? 32'hFFFF_FFFF : big[31:0];
      end
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// File: design/sd_card_spi_host_sequencer.sv
// Top level of the SD card SPI-mode host sequencer.
// Depends on sdspi_pkg.
//
// Usage: the host drives items on the in_ channel (opcode plus address, received
// byte and write data). Start opcodes launch init, block read, block write or
// capacity query; received-byte items report what the card returned for the last
// transmitted byte; tick items mark milliseconds; write-data items supply bytes.
// Each accepted item yields zero or one result item on the out_ channel, telling
// which byte to shift out next, chip select and clock speed, read data, write data
// requests and completion status.
// Each result is registered on out_; while out_stall holds a result there, the next one waits in the skid stage.
// Throughput: one item per cycle while in_stall is low; the whole transition is one registered pass.
// A result register and a one-entry skid stage keep the input open while a
// result waits; in_stall rises only when both hold a result.
// Configuration writes are taken at any cycle through cfg_ (cfg_ready is high)
// and must be issued while the sequencer is idle.
// Reset (rst_n low at a clock edge) returns to idle, slow clock, byte addressing,
// default register values, and drops any pending result.
module sd_card_spi_host_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_block_address,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_chip_select,
  output logic        out_fast_clock,
  output logic        out_read_valid,
  output logic [7:0]  out_read_byte,
  output logic        out_data_request,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic [31:0] out_capacity_blocks,
  output logic        out_high_capacity,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_CAP   = 3'd3;
  localparam logic [2:0] OP_RX    = 3'd4;
  localparam logic [2:0] OP_TICK  = 3'd5;
  localparam logic [2:0] OP_WDATA = 3'd6;

  localparam logic [2:0] REG_INIT_TO  = 3'd0;
  localparam logic [2:0] REG_TOKEN_TO = 3'd1;
  localparam logic [2:0] REG_BUSY_TO  = 3'd2;
  localparam logic [2:0] REG_POLL     = 3'd3;
  localparam logic [2:0] REG_CMD0     = 3'd4;
  localparam logic [2:0] REG_WAKE     = 3'd5;

  localparam logic [4:0] PH_IDLE = 5'd0,  PH_WAKE = 5'd1,  PH_C0 = 5'd2,    PH_GAP = 5'd3;
  localparam logic [4:0] PH_C8 = 5'd4,    PH_R7 = 5'd5,    PH_C55V2 = 5'd6, PH_A41V2 = 5'd7;
  localparam logic [4:0] PH_C55V1 = 5'd8, PH_A41V1 = 5'd9, PH_C58 = 5'd10,  PH_OCR = 5'd11;
  localparam logic [4:0] PH_C17 = 5'd12,  PH_RTOK = 5'd13, PH_RDAT = 5'd14, PH_C24 = 5'd15;
  localparam logic [4:0] PH_WTOK = 5'd16, PH_WDREQ = 5'd17, PH_WDAT = 5'd18;
  localparam logic [4:0] PH_WCRC = 5'd19, PH_WRESP = 5'd20, PH_BUSY = 5'd21;
  localparam logic [4:0] PH_C9 = 5'd22,   PH_CTOK = 5'd23, PH_CDAT = 5'd24;

  logic [15:0] init_to_r, token_to_r, busy_to_r;
  logic [7:0]  poll_lim_r, wake_bytes_r;
  logic [3:0]  cmd0_att_r;

  logic [4:0]  ph_r, ph_nxt;
  logic [9:0]  bc_r, bc_nxt;
  logic [15:0] el_r, el_nxt;
  logic [3:0]  att_r, att_nxt;
  logic        cba_r, cba_nxt;
  logic        fast_r, fast_nxt;
  logic [47:0] frame_r, frame_nxt;
  logic [7:0]  csd_r [16];

  logic        csd_we;
  logic [3:0]  csd_wa;
  sdspi_pkg::res_t res;
  logic        res_v;
  sdspi_pkg::csd_t csd_dec;

  sdspi_pkg::res_t out_r, skid_r;
  logic        out_v_r, skid_v_r;
  logic        in_acc;

  logic        iss;
  logic [4:0]  iss_ph;
  logic [47:0] iss_frame;
  logic        fin;
  logic [2:0]  fin_st;
  logic        run;
  logic [7:0]  r1;
  logic [3:0]  att_inc;
  logic [31:0] addr;

  assign in_stall  = skid_v_r;
  assign in_acc    = in_valid && !skid_v_r;
  assign cfg_ready = 1'b1;

  assign csd_dec = sdspi_pkg::decode_csd(csd_r[0], csd_r[5], csd_r[6], csd_r[7],
                                         csd_r[8], csd_r[9], csd_r[10]);
  assign att_inc = att_r + 4'd1;
  assign addr = cba_r ? in_block_address : {in_block_address[22:0], 9'd0};

  always_comb begin
    ph_nxt = ph_r;
    bc_nxt = bc_r;
    el_nxt = el_r;
    att_nxt = att_r;
    cba_nxt = cba_r;
    fast_nxt = fast_r;
    frame_nxt = frame_r;
    csd_we = 1'b0;
    csd_wa = bc_r[3:0];
    res = '0;
    iss = 1'b0;
    iss_ph = PH_IDLE;
    iss_frame = '0;
    fin = 1'b0;
    fin_st = sdspi_pkg::ST_OK;
    run = 1'b0;
    r1 = 8'hFF;
    if (in_acc) begin
      case (in_opcode)
        OP_INIT, OP_READ, OP_WRITE, OP_CAP: begin
          if (ph_r == PH_IDLE) begin
            case (in_opcode)
              OP_INIT: begin
                cba_nxt = 1'b0;
                fast_nxt = 1'b0;
                ph_nxt = PH_WAKE;
                bc_nxt = 10'd1;
                res.tx_valid = 1'b1;
                res.tx_byte = 8'hFF;
              end
              OP_READ: begin
                iss = 1'b1;
                iss_ph = PH_C17;
                iss_frame = sdspi_pkg::make_frame(8'h11, addr, 8'h01);
              end
              OP_WRITE: begin
                iss = 1'b1;
                iss_ph = PH_C24;
                iss_frame = sdspi_pkg::make_frame(8'h18, addr, 8'h01);
              end
              default: begin
                iss = 1'b1;
                iss_ph = PH_C9;
                iss_frame = sdspi_pkg::make_frame(8'h09, 32'd0, 8'h01);
              end
            endcase
          end
        end
        OP_TICK: begin
          if (el_r != 16'hFFFF) el_nxt = el_r + 16'd1;
        end
        OP_WDATA: begin
          if (ph_r == PH_WDREQ) begin
            ph_nxt = PH_WDAT;
            res.tx_valid = 1'b1;
            res.tx_byte = in_write_byte;
          end
        end
        OP_RX: begin
          if (ph_r != PH_IDLE && ph_r != PH_WDREQ) begin
            if (ph_r inside {PH_C0, PH_C8, PH_C55V2, PH_A41V2, PH_C55V1, PH_A41V1,
                             PH_C58, PH_C17, PH_C24, PH_C9}) begin
              if (bc_r < 10'd7) begin
                res.tx_valid = 1'b1;
                res.tx_byte = sdspi_pkg::frame_byte(frame_r, bc_r[2:0]);
                bc_nxt = bc_r + 10'd1;
                run = 1'b1;
              end else if (bc_r == 10'd7) begin
                res.tx_valid = 1'b1;
                res.tx_byte = 8'hFF;
                bc_nxt = 10'd8;
                run = 1'b1;
              end else if (!in_rx_byte[7]) begin
                r1 = in_rx_byte;
              end else if ((bc_r - 10'd7) >= {2'b00, poll_lim_r}) begin
                r1 = 8'hFF;
              end else begin
                res.tx_valid = 1'b1;
                res.tx_byte = 8'hFF;
                bc_nxt = bc_r + 10'd1;
                run = 1'b1;
              end
            end
            if (!run) begin
              case (ph_r)
                PH_WAKE: begin
                  if (bc_r < {2'b00, wake_bytes_r}) begin
                    bc_nxt = bc_r + 10'd1;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end else begin
                    el_nxt = '0;
                    att_nxt = '0;
                    iss = 1'b1;
                    iss_ph = PH_C0;
                    iss_frame = sdspi_pkg::make_frame(8'h00, 32'd0, 8'h95);
                  end
                end
                PH_C0: begin
                  if (r1 == 8'h01) begin
                    iss = 1'b1;
                    iss_ph = PH_C8;
                    iss_frame = sdspi_pkg::make_frame(8'h08, 32'h0000_01AA, 8'h87);
                  end else if (el_r > init_to_r) begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_CMD0;
                  end else begin
                    ph_nxt = PH_GAP;
                    bc_nxt = 10'd1;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end
                end
                PH_GAP: begin
                  if (bc_r < 10'd8) begin
                    bc_nxt = bc_r + 10'd1;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end else begin
                    att_nxt = att_inc;
                    if (att_inc >= cmd0_att_r) begin
                      fin = 1'b1;
                      fin_st = sdspi_pkg::ST_CMD0;
                    end else begin
                      iss = 1'b1;
                      iss_ph = PH_C0;
                      iss_frame = sdspi_pkg::make_frame(8'h00, 32'd0, 8'h95);
                    end
                  end
                end
                PH_C8: begin
                  if (r1 == 8'h01) begin
                    ph_nxt = PH_R7;
                    bc_nxt = 10'd1;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end else if (r1 == 8'h05) begin
                    el_nxt = '0;
                    iss = 1'b1;
                    iss_ph = PH_C55V1;
                    iss_frame = sdspi_pkg::make_frame(8'h37, 32'd0, 8'h01);
                  end else begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_CMD8;
                  end
                end
                PH_R7: begin
                  if (bc_r < 10'd4) begin
                    bc_nxt = bc_r + 10'd1;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end else if (in_rx_byte != 8'hAA) begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_CMD8;
                  end else begin
                    el_nxt = '0;
                    iss = 1'b1;
                    iss_ph = PH_C55V2;
                    iss_frame = sdspi_pkg::make_frame(8'h37, 32'd0, 8'h01);
                  end
                end
                PH_C55V2, PH_C55V1: begin
                  if (r1 > 8'd1) begin
                    if (el_r >= init_to_r) begin
                      fin = 1'b1;
                      fin_st = sdspi_pkg::ST_ACMD41;
                    end else begin
                      iss = 1'b1;
                      iss_ph = ph_r;
                      iss_frame = sdspi_pkg::make_frame(8'h37, 32'd0, 8'h01);
                    end
                  end else begin
                    iss = 1'b1;
                    iss_ph = (ph_r == PH_C55V2) ? PH_A41V2 : PH_A41V1;
                    iss_frame = sdspi_pkg::make_frame(8'h29,
                      (ph_r == PH_C55V2) ? 32'h4000_0000 : 32'd0, 8'h01);
                  end
                end
                PH_A41V2, PH_A41V1: begin
                  if (r1 == 8'd0 && ph_r == PH_A41V2) begin
                    iss = 1'b1;
                    iss_ph = PH_C58;
                    iss_frame = sdspi_pkg::make_frame(8'h3A, 32'd0, 8'h01);
                  end else if (r1 == 8'd0) begin
                    cba_nxt = 1'b0;
                    fast_nxt = 1'b1;
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_OK;
                  end else if (el_r >= init_to_r) begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_ACMD41;
                  end else begin
                    iss = 1'b1;
                    iss_ph = (ph_r == PH_A41V2) ? PH_C55V2 : PH_C55V1;
                    iss_frame = sdspi_pkg::make_frame(8'h37, 32'd0, 8'h01);
                  end
                end
                PH_C58: begin
                  if (r1 != 8'd0) begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_CMD58;
                  end else begin
                    ph_nxt = PH_OCR;
                    bc_nxt = 10'd1;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end
                end
                PH_OCR: begin
                  if (bc_r == 10'd1 && in_rx_byte[7:6] == 2'b11) cba_nxt = 1'b1;
                  if (bc_r < 10'd4) begin
                    bc_nxt = bc_r + 10'd1;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end else begin
                    fast_nxt = 1'b1;
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_OK;
                  end
                end
                PH_C17, PH_C9: begin
                  if (r1 != 8'd0) begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_READ;
                  end else begin
                    el_nxt = '0;
                    ph_nxt = (ph_r == PH_C17) ? PH_RTOK : PH_CTOK;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end
                end
                PH_RTOK: begin
                  if (in_rx_byte == 8'hFE) begin
                    ph_nxt = PH_RDAT;
                    bc_nxt = '0;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end else if (el_r >= token_to_r) begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_TIMEOUT;
                  end else begin
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end
                end
                PH_RDAT: begin
                  if (bc_r < sdspi_pkg::BLOCK_BC) begin
                    res.read_valid = 1'b1;
                    res.read_byte = in_rx_byte;
                    bc_nxt = bc_r + 10'd1;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end else if (bc_r == sdspi_pkg::BLOCK_BC) begin
                    bc_nxt = bc_r + 10'd1;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end else begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_OK;
                  end
                end
                PH_C24: begin
                  if (r1 != 8'd0) begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_WRITE;
                  end else begin
                    ph_nxt = PH_WTOK;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFE;
                  end
                end
                PH_WTOK: begin
                  bc_nxt = '0;
                  ph_nxt = PH_WDREQ;
                  res.data_request = 1'b1;
                end
                PH_WDAT: begin
                  if (bc_r + 10'd1 < sdspi_pkg::BLOCK_BC) begin
                    bc_nxt = bc_r + 10'd1;
                    ph_nxt = PH_WDREQ;
                    res.data_request = 1'b1;
                  end else begin
                    ph_nxt = PH_WCRC;
                    bc_nxt = '0;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end
                end
                PH_WCRC: begin
                  if (bc_r == 10'd0) bc_nxt = 10'd1;
                  else ph_nxt = PH_WRESP;
                  res.tx_valid = 1'b1;
                  res.tx_byte = 8'hFF;
                end
                PH_WRESP: begin
                  if (in_rx_byte[4:0] != 5'h05) begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_WRITE;
                  end else begin
                    el_nxt = '0;
                    ph_nxt = PH_BUSY;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end
                end
                PH_BUSY: begin
                  if (in_rx_byte == 8'hFF) begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_OK;
                  end else if (el_r >= busy_to_r) begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_TIMEOUT;
                  end else begin
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end
                end
                PH_CTOK: begin
                  if (in_rx_byte == 8'hFE) begin
                    ph_nxt = PH_CDAT;
                    bc_nxt = '0;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end else if (el_r > token_to_r) begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_READ;
                  end else begin
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end
                end
                PH_CDAT: begin
                  if (bc_r < 10'd16) begin
                    csd_we = 1'b1;
                    bc_nxt = bc_r + 10'd1;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end else if (bc_r == 10'd16) begin
                    bc_nxt = bc_r + 10'd1;
                    res.tx_valid = 1'b1;
                    res.tx_byte = 8'hFF;
                  end else if (csd_dec.ok) begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_OK;
                    res.capacity_blocks = csd_dec.blocks;
                  end else begin
                    fin = 1'b1;
                    fin_st = sdspi_pkg::ST_READ;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (iss) begin
      frame_nxt = iss_frame;
      ph_nxt = iss_ph;
      bc_nxt = 10'd1;
      res.tx_valid = 1'b1;
      res.tx_byte = 8'hFF;
    end
    if (fin) begin
      ph_nxt = PH_IDLE;
      res.done_res = 1'b1;
      res.status = fin_st;
    end
    res.chip_select = (ph_nxt != PH_IDLE) && (ph_nxt != PH_WAKE);
    res.fast_clock = fast_nxt;
    res.high_capacity = cba_nxt;
    res_v = res.tx_valid || res.read_valid || res.data_request || res.done_res;
  end

  always_ff @(posedge clk) begin
    if (csd_we) csd_r[csd_wa] <= in_rx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      bc_r <= '0;
      el_r <= '0;
      att_r <= '0;
      cba_r <= 1'b0;
      fast_r <= 1'b0;
      frame_r <= '0;
      init_to_r <= sdspi_pkg::INIT_TIMEOUT_RST;
      token_to_r <= sdspi_pkg::TOKEN_TIMEOUT_RST;
      busy_to_r <= sdspi_pkg::BUSY_TIMEOUT_RST;
      poll_lim_r <= sdspi_pkg::POLL_LIMIT_RST;
      cmd0_att_r <= sdspi_pkg::CMD0_ATTEMPTS_RST;
      wake_bytes_r <= sdspi_pkg::WAKEUP_BYTES_RST;
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      bc_r <= bc_nxt;
      el_r <= el_nxt;
      att_r <= att_nxt;
      cba_r <= cba_nxt;
      fast_r <= fast_nxt;
      frame_r <= frame_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_INIT_TO:  init_to_r <= cfg_data;
          REG_TOKEN_TO: token_to_r <= cfg_data;
          REG_BUSY_TO:  busy_to_r <= cfg_data;
          REG_POLL:     poll_lim_r <= cfg_data[7:0];
          REG_CMD0:     cmd0_att_r <= cfg_data[3:0];
          REG_WAKE:     wake_bytes_r <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (!out_v_r || !out_stall) begin
        if (skid_v_r) begin
          out_v_r <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= res_v;
        end
      end else if (res_v) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (res_v) begin
      skid_r <= res;
    end
  end

  assign out_valid           = out_v_r;
  assign out_tx_valid        = out_r.tx_valid;
  assign out_tx_byte         = out_r.tx_byte;
  assign out_chip_select     = out_r.chip_select;
  assign out_fast_clock      = out_r.fast_clock;
  assign out_read_valid      = out_r.read_valid;
  assign out_read_byte       = out_r.read_byte;
  assign out_data_request    = out_r.data_request;
  assign out_done_res        = out_r.done_res;
  assign out_status          = out_r.status;
  assign out_capacity_blocks = out_r.capacity_blocks;
  assign out_high_capacity   = out_r.high_capacity;

endmodule

// File: design/sdspi_checker.sv
// Port-level checker for the SD SPI host sequencer, bound to the top level.
// Depends on assert_macros.svh and sdspi_pkg.
`include "assert_macros.svh"
module sdspi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_tx_valid,
  input logic [7:0]  out_tx_byte,
  input logic        out_done_res,
  input logic [2:0]  out_status,
  input logic        out_read_valid,
  input logic [7:0]  out_read_byte
);

  `ASSERT_IMPL(a_stall_needs_result, clk, rst_n, in_stall, out_valid)
  `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall,
               out_valid && $stable(out_tx_byte) && $stable(out_status))
  `ASSERT_IMPL(a_tx_byte_zero, clk, rst_n, out_valid && !out_tx_valid, out_tx_byte == 8'd0)
  `ASSERT_IMPL(a_status_done, clk, rst_n, out_valid && !out_done_res,
               out_status == sdspi_pkg::ST_OK)
  `ASSERT_IMPL(a_read_byte_zero, clk, rst_n, out_valid && !out_read_valid,
               out_read_byte == 8'd0)

endmodule

bind sd_card_spi_host_sequencer sdspi_checker u_sdspi_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_tx_valid(out_tx_valid),
  .out_tx_byte(out_tx_byte),
  .out_done_res(out_done_res),
  .out_status(out_status),
  .out_read_valid(out_read_valid),
  .out_read_byte(out_read_byte)
);
